// ===== hdl/stq_pkg.sv =====
// Package for the sorted timer queue: field widths, codes and shared types.
`timescale 1ns / 1ps

package stq_pkg;

  localparam int TIMER_SLOTS_DEF = 16;
  // Pops per tick are capped; the rest wait for the following ticks.
  localparam int MAX_POPS        = 16;
  localparam int CNT_W           = $clog2(MAX_POPS);

  localparam int NOW_W     = 64;
  localparam int TIMEOUT_W = 32;
  localparam int ID_W      = 4;
  localparam int TAG_W     = 32;
  localparam int OP_W      = 2;
  localparam int EV_W      = 3;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [EV_W-1:0] {
    EV_STARTED   = 3'd0,
    EV_STOPPED   = 3'd1,
    EV_EXPIRED   = 3'd2,
    EV_REJECTED  = 3'd3,
    EV_NOT_FOUND = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_POP,
    CELL_CLEAR
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_t;

  // Command broadcast to every cell; key is the new expiry on insert and
  // the current time while popping.
  typedef struct packed {
    cell_op_t         op;
    logic [NOW_W-1:0] key;
  } cell_ctl_t;

endpackage

// ===== hdl/stq_cell.sv =====
// One cell of the sorted chain: holds a timer entry and shifts with its neighbors.
`timescale 1ns / 1ps

module stq_cell #(
  parameter int SLOT_W = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stq_pkg::cell_ctl_t         ctl,
  input  logic [SLOT_W-1:0]          new_slot,
  input  logic [stq_pkg::TAG_W-1:0]  new_tag,
  input  logic [stq_pkg::ID_W-1:0]   match_id,
  input  logic                       shift_up,
  input  logic                       left_le,
  input  logic                       left_valid,
  input  logic [stq_pkg::NOW_W-1:0]  left_expiry,
  input  logic [SLOT_W-1:0]          left_slot,
  input  logic [stq_pkg::TAG_W-1:0]  left_tag,
  input  logic                       right_valid,
  input  logic [stq_pkg::NOW_W-1:0]  right_expiry,
  input  logic [SLOT_W-1:0]          right_slot,
  input  logic [stq_pkg::TAG_W-1:0]  right_tag,
  output logic                       le,
  output logic                       match,
  output logic                       valid,
  output logic [stq_pkg::NOW_W-1:0]  expiry,
  output logic [SLOT_W-1:0]          slot,
  output logic [stq_pkg::TAG_W-1:0]  tag
);

  localparam int CMP_W = (SLOT_W > stq_pkg::ID_W) ? SLOT_W : stq_pkg::ID_W;

  logic                      valid_r, valid_nxt;
  logic [stq_pkg::NOW_W-1:0] expiry_r, expiry_nxt;
  logic [SLOT_W-1:0]         slot_r, slot_nxt;
  logic [stq_pkg::TAG_W-1:0] tag_r, tag_nxt;

  assign le    = valid_r && (expiry_r <= ctl.key);
  assign match = valid_r && (CMP_W'(slot_r) == CMP_W'(match_id));

  always_comb begin
    valid_nxt  = valid_r;
    expiry_nxt = expiry_r;
    slot_nxt   = slot_r;
    tag_nxt    = tag_r;
    case (ctl.op)
      stq_pkg::CELL_INSERT: begin
        if (!le) begin
          if (!left_le) begin
            // cell before us moves back, so take its entry
            valid_nxt  = left_valid;
            expiry_nxt = left_expiry;
            slot_nxt   = left_slot;
            tag_nxt    = left_tag;
          end else begin
            valid_nxt  = 1'b1;
            expiry_nxt = ctl.key;
            slot_nxt   = new_slot;
            tag_nxt    = new_tag;
          end
        end
      end
      stq_pkg::CELL_REMOVE, stq_pkg::CELL_POP: begin
        if (shift_up || ctl.op == stq_pkg::CELL_POP) begin
          valid_nxt  = right_valid;
          expiry_nxt = right_expiry;
          slot_nxt   = right_slot;
          tag_nxt    = right_tag;
        end
      end
      stq_pkg::CELL_CLEAR: valid_nxt = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    expiry_r <= expiry_nxt;
    slot_r   <= slot_nxt;
    tag_r    <= tag_nxt;
  end

  assign valid  = valid_r;
  assign expiry = expiry_r;
  assign slot   = slot_r;
  assign tag    = tag_r;

endmodule

// ===== hdl/stq_chain.sv =====
// Row of sorted timer cells with neighbor wiring and the removal shift mask.
`timescale 1ns / 1ps

module stq_chain #(
  parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF,
  parameter int SLOT_W      = $clog2(TIMER_SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  stq_pkg::cell_ctl_t         ctl,
  input  logic [SLOT_W-1:0]          new_slot,
  input  logic [stq_pkg::TAG_W-1:0]  new_tag,
  input  logic [stq_pkg::ID_W-1:0]   match_id,
  output logic [TIMER_SLOTS-1:0]     le_vec,
  output logic [TIMER_SLOTS-1:0]     valid_vec,
  output logic [stq_pkg::NOW_W-1:0]  head_expiry,
  output logic [stq_pkg::NOW_W-1:0]  second_expiry,
  output logic [SLOT_W-1:0]          head_slot,
  output logic [stq_pkg::TAG_W-1:0]  head_tag
);

  logic [TIMER_SLOTS-1:0]    match_vec;
  logic [TIMER_SLOTS-1:0]    after_vec;
  logic [stq_pkg::NOW_W-1:0] expiry_a [TIMER_SLOTS];
  logic [SLOT_W-1:0]         slot_a   [TIMER_SLOTS];
  logic [stq_pkg::TAG_W-1:0] tag_a    [TIMER_SLOTS];

  genvar g;
  generate
    for (g = 0; g < TIMER_SLOTS; g++) begin : g_cell
      logic                      l_le, l_valid, r_valid;
      logic [stq_pkg::NOW_W-1:0] l_expiry, r_expiry;
      logic [SLOT_W-1:0]         l_slot, r_slot;
      logic [stq_pkg::TAG_W-1:0] l_tag, r_tag;

      // cells at and after the stopped entry shift toward the head
      assign after_vec[g] = |match_vec[g:0];

      if (g == 0) begin : g_first
        assign l_le     = 1'b1;
        assign l_valid  = 1'b0;
        assign l_expiry = '0;
        assign l_slot   = '0;
        assign l_tag    = '0;
      end else begin : g_mid
        assign l_le     = le_vec[g-1];
        assign l_valid  = valid_vec[g-1];
        assign l_expiry = expiry_a[g-1];
        assign l_slot   = slot_a[g-1];
        assign l_tag    = tag_a[g-1];
      end

      if (g == TIMER_SLOTS - 1) begin : g_last
        assign r_valid  = 1'b0;
        assign r_expiry = '0;
        assign r_slot   = '0;
        assign r_tag    = '0;
      end else begin : g_inner
        assign r_valid  = valid_vec[g+1];
        assign r_expiry = expiry_a[g+1];
        assign r_slot   = slot_a[g+1];
        assign r_tag    = tag_a[g+1];
      end

      stq_cell #(.SLOT_W(SLOT_W)) u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .new_slot     (new_slot),
        .new_tag      (new_tag),
        .match_id     (match_id),
        .shift_up     (after_vec[g]),
        .left_le      (l_le),
        .left_valid   (l_valid),
        .left_expiry  (l_expiry),
        .left_slot    (l_slot),
        .left_tag     (l_tag),
        .right_valid  (r_valid),
        .right_expiry (r_expiry),
        .right_slot   (r_slot),
        .right_tag    (r_tag),
        .le           (le_vec[g]),
        .match        (match_vec[g]),
        .valid        (valid_vec[g]),
        .expiry       (expiry_a[g]),
        .slot         (slot_a[g]),
        .tag          (tag_a[g])
      );
    end
  endgenerate

  assign head_expiry   = expiry_a[0];
  assign second_expiry = expiry_a[1];
  assign head_slot     = slot_a[0];
  assign head_tag      = tag_a[0];

endmodule

// ===== hdl/sorted_timer_queue_top.sv =====
// Top level of the sorted one-shot timer queue.
//
//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------------------
//  in      | in_tvalid/in_tready/in_tdata/  | command: start, stop or one-ms tick
//          | in_tuser                       |
//  out     | out_tvalid/out_tready/out_tdata| result events, tlast on the final one
//          | /out_tuser/out_tlast           |
//  cfg     | cfg_we/cfg_wdata               | enable register write
//
// Start and stop use a single shift of the cell chain, which inserts or closes the gap.
// A tick advances the counter, then pops expired timers from the head of the chain
// (at most 16 per tick) until none is due. The output register frees the chain from
// the consumer; a stalled out_tready holds the pop sequence and in_tready. Reset is
// synchronous and leaves an empty queue.
`timescale 1ns / 1ps

module sorted_timer_queue_top #(
  parameter int TIMER_SLOTS = stq_pkg::TIMER_SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // timeout_ms[31:0], timer_id[35:32], user_tag[67:36], zero pad[71:68]
  input  logic [stq_pkg::IN_DATA_W-1:0]   in_tdata,
  // operation[1:0]
  input  logic [stq_pkg::OP_W-1:0]        in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // timer_id_res[3:0], user_tag_res[35:4], zero pad[39:36]
  output logic [stq_pkg::OUT_DATA_W-1:0]  out_tdata,
  // event_res[2:0]
  output logic [stq_pkg::EV_W-1:0]        out_tuser,
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic                            cfg_wdata
);

  localparam int SLOT_W = $clog2(TIMER_SLOTS);
  localparam int CNT_W  = stq_pkg::CNT_W;

  stq_pkg::state_t           state_r, state_nxt;
  logic                      enable_r;
  logic [stq_pkg::NOW_W-1:0] now_r, now_nxt;
  logic [TIMER_SLOTS-1:0]    busy_r, busy_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;

  logic                      out_valid_r;
  logic [stq_pkg::EV_W-1:0]  out_ev_r, out_ev_nxt;
  logic [stq_pkg::ID_W-1:0]  out_id_r, out_id_nxt;
  logic [stq_pkg::TAG_W-1:0] out_tag_r, out_tag_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_load;
  logic                      out_free;

  logic                          in_fire;
  stq_pkg::op_t                  in_op;
  logic [stq_pkg::TIMEOUT_W-1:0] in_timeout;
  logic [stq_pkg::ID_W-1:0]      in_id;
  logic [stq_pkg::TAG_W-1:0]     in_tag;

  logic [stq_pkg::NOW_W:0]   exp_sum;
  logic [stq_pkg::NOW_W-1:0] exp_sat;
  logic [TIMER_SLOTS-1:0]    free_vec, first_free;
  logic [SLOT_W-1:0]         free_idx;
  logic                      table_full;
  logic                      id_in_range;
  logic [SLOT_W-1:0]         id_slot;
  logic                      stop_hit;
  logic                      cfg_clear;

  stq_pkg::cell_ctl_t        ctl;
  logic [TIMER_SLOTS-1:0]    le_vec, valid_vec;
  logic [stq_pkg::NOW_W-1:0] head_expiry, second_expiry;
  logic [SLOT_W-1:0]         head_slot;
  logic [stq_pkg::TAG_W-1:0] head_tag;

  assign in_op      = stq_pkg::op_t'(in_tuser);
  assign in_timeout = in_tdata[31:0];
  assign in_id      = in_tdata[35:32];
  assign in_tag     = in_tdata[67:36];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == stq_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_clear = cfg_we && enable_r && !cfg_wdata;

  // saturate the absolute expiry at the top of the counter range
  assign exp_sum = {1'b0, now_r} + (stq_pkg::NOW_W + 1)'(in_timeout);
  assign exp_sat = exp_sum[stq_pkg::NOW_W] ? '1 : exp_sum[stq_pkg::NOW_W-1:0];

  // lowest free slot: isolate the lowest set bit, then encode it
  assign free_vec   = ~busy_r;
  assign first_free = free_vec & (~free_vec + TIMER_SLOTS'(1));
  assign table_full = &busy_r;

  always_comb begin
    free_idx = '0;
    for (int j = 0; j < TIMER_SLOTS; j++) begin
      if (first_free[j]) free_idx = free_idx | SLOT_W'(j);
    end
  end

  assign id_in_range = int'(in_id) < TIMER_SLOTS;
  assign id_slot     = SLOT_W'(in_id);
  assign stop_hit    = id_in_range && busy_r[id_slot];

  stq_chain #(
    .TIMER_SLOTS (TIMER_SLOTS),
    .SLOT_W      (SLOT_W)
  ) u_chain (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .new_slot      (free_idx),
    .new_tag       (in_tag),
    .match_id      (in_id),
    .le_vec        (le_vec),
    .valid_vec     (valid_vec),
    .head_expiry   (head_expiry),
    .second_expiry (second_expiry),
    .head_slot     (head_slot),
    .head_tag      (head_tag)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stq_pkg::ST_IDLE: begin
        if (in_fire && in_op == stq_pkg::OP_TICK) state_nxt = stq_pkg::ST_POP;
      end
      stq_pkg::ST_POP: begin
        if (!le_vec[0]) begin
          state_nxt = stq_pkg::ST_IDLE;
        end else if (out_free && (cnt_r == CNT_W'(stq_pkg::MAX_POPS - 1) || !le_vec[1])) begin
          state_nxt = stq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stq_pkg::ST_IDLE;
    endcase
  end

  // datapath control and result
  always_comb begin
    ctl.op       = stq_pkg::CELL_HOLD;
    ctl.key      = (state_r == stq_pkg::ST_POP) ? now_r : exp_sat;
    now_nxt      = now_r;
    busy_nxt     = busy_r;
    cnt_nxt      = cnt_r;
    out_load     = 1'b0;
    out_ev_nxt   = stq_pkg::EV_STARTED;
    out_id_nxt   = '0;
    out_tag_nxt  = '0;
    out_last_nxt = 1'b1;
    unique case (state_r)
      stq_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_op)
            stq_pkg::OP_START: begin
              out_load = 1'b1;
              if (!enable_r || in_timeout[stq_pkg::TIMEOUT_W-1] || table_full) begin
                out_ev_nxt = stq_pkg::EV_REJECTED;
              end else begin
                ctl.op             = stq_pkg::CELL_INSERT;
                busy_nxt[free_idx] = 1'b1;
                out_ev_nxt         = stq_pkg::EV_STARTED;
                out_id_nxt         = stq_pkg::ID_W'(free_idx);
              end
            end
            stq_pkg::OP_STOP: begin
              out_load   = 1'b1;
              out_id_nxt = in_id;
              if (!enable_r) begin
                out_ev_nxt = stq_pkg::EV_STOPPED;
              end else if (stop_hit) begin
                ctl.op            = stq_pkg::CELL_REMOVE;
                busy_nxt[id_slot] = 1'b0;
                out_ev_nxt        = stq_pkg::EV_STOPPED;
              end else begin
                out_ev_nxt = stq_pkg::EV_NOT_FOUND;
              end
            end
            stq_pkg::OP_TICK: begin
              if (now_r != '1) now_nxt = now_r + stq_pkg::NOW_W'(1);
              cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      stq_pkg::ST_POP: begin
        if (le_vec[0] && out_free) begin
          ctl.op              = stq_pkg::CELL_POP;
          busy_nxt[head_slot] = 1'b0;
          cnt_nxt             = cnt_r + CNT_W'(1);
          out_load            = 1'b1;
          out_ev_nxt          = stq_pkg::EV_EXPIRED;
          out_id_nxt          = stq_pkg::ID_W'(head_slot);
          out_tag_nxt         = head_tag;
          out_last_nxt        = (cnt_r == CNT_W'(stq_pkg::MAX_POPS - 1)) || !le_vec[1];
        end
      end
      default: ;
    endcase
    // shutdown drops every live timer
    if (cfg_clear) begin
      ctl.op   = stq_pkg::CELL_CLEAR;
      busy_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stq_pkg::ST_IDLE;
      enable_r    <= 1'b0;
      now_r       <= '0;
      busy_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      now_r    <= now_nxt;
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      if (cfg_we) enable_r <= cfg_wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ev_r   <= out_ev_nxt;
      out_id_r   <= out_id_nxt;
      out_tag_r  <= out_tag_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(stq_pkg::OUT_DATA_W - stq_pkg::ID_W - stq_pkg::TAG_W){1'b0}},
                       out_tag_r, out_id_r};

  // the number of live cells equals the number of busy slots
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == $countones(busy_r))
    else $error("live cell count differs from busy slot count");

  // live cells stay packed at the head of the chain
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + TIMER_SLOTS'(1))) == '0)
    else $error("hole in the cell chain");

  a_sorted_head: assert property (@(posedge clk) disable iff (!rst_n)
    valid_vec[1] |-> head_expiry <= second_expiry)
    else $error("head cells out of order");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("result loaded over a pending transfer");

  a_pop_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stq_pkg::ST_POP) |-> !in_tready)
    else $error("input taken while popping expired timers");

endmodule
